// ----- src/ert_pkg.sv -----
// Shared types and constants for the event rate throttle.
package ert_pkg;

  // Field widths
  localparam int unsigned LevelW     = 17;
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned CostW      = 8;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned CfgDataW   = 16;

  // Saturation point of the fill level
  localparam logic [LevelW-1:0] LevelMax = {LevelW{1'b1}};

  // Register reset values
  localparam logic [ThreshW-1:0] ThreshReset = 16'd100;
  localparam logic [CostW-1:0]   CostReset   = 8'd10;

  // Register indexes
  localparam logic [CfgIndexW-1:0] RegThreshold = 1'd0;
  localparam logic [CfgIndexW-1:0] RegCost      = 1'd1;

  // Operation codes
  localparam logic OpEvent = 1'b0;
  localparam logic OpTick  = 1'b1;

  // Throttle mode
  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_THROTTLING = 2'd1,
    MODE_THROTTLED  = 2'd2
  } mode_t;

  // Configuration seen by the core
  typedef struct packed {
    logic [ThreshW-1:0] threshold;
    logic [CostW-1:0]   cost;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [1:0] throttle_mode;
    logic       clear_alarm;
    logic       raise_alarm;
    logic       forward_event;
  } result_t;

endpackage

// ----- src/ert_cfg.sv -----
// Configuration registers of the event rate throttle.
module ert_cfg
  import ert_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                 cfg
);

  logic [ThreshW-1:0] threshold;
  logic [CostW-1:0]   cost;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThreshReset;
      cost      <= CostReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegThreshold: threshold <= cfg_data[ThreshW-1:0];
        RegCost:      cost      <= cfg_data[CostW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.threshold = threshold;
  assign cfg.cost      = cost;

endmodule

// ----- src/ert_core.sv -----
// Bucket state and per-word step logic of the event rate throttle.
module ert_core
  import ert_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,       // advance state with the word below
  input  logic    operation,
  input  logic    is_measurement,
  output result_t result
);

  logic [LevelW-1:0] fill_level, fill_level_next;
  mode_t             mode, mode_next;

  logic [LevelW:0]   sum;
  logic [LevelW-1:0] level_ev;
  logic              below;
  logic              add_cost;

  // Step logic: one add with saturation, one compare, mode update
  always_comb begin
    add_cost = !is_measurement && (mode == MODE_NONE);
    sum      = {1'b0, fill_level} + {{(LevelW+1-CostW){1'b0}}, cfg.cost};
    level_ev = fill_level;
    if (add_cost) begin
      level_ev = sum[LevelW] ? LevelMax : sum[LevelW-1:0];
    end
    below = level_ev < {{(LevelW-ThreshW){1'b0}}, cfg.threshold};

    fill_level_next      = fill_level;
    mode_next            = mode;
    result.forward_event = 1'b0;
    result.raise_alarm   = 1'b0;
    result.clear_alarm   = 1'b0;

    if (operation == OpEvent) begin
      fill_level_next = level_ev;
      if (below) begin
        result.forward_event = 1'b1;
        mode_next            = MODE_NONE;
      end else begin
        unique case (mode)
          MODE_NONE: begin
            result.raise_alarm = 1'b1;
            mode_next          = MODE_THROTTLING;
          end
          MODE_THROTTLING: begin
            result.forward_event = 1'b1;
            mode_next            = MODE_THROTTLED;
          end
          default: ;
        endcase
      end
    end else begin
      // Tick: clear on exact match, then leak one unit
      if (fill_level == {{(LevelW-ThreshW){1'b0}}, cfg.threshold}) begin
        result.clear_alarm = 1'b1;
      end
      if (fill_level != '0) begin
        fill_level_next = fill_level - LevelW'(1);
      end
    end
    result.throttle_mode = mode_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
      mode       <= MODE_NONE;
    end else if (step) begin
      fill_level <= fill_level_next;
      mode       <= mode_next;
    end
  end

endmodule

// ----- src/event_rate_throttle.sv -----
// Event rate throttle top level: input register, step core, result register.
// An accepted word passes the input register, then the result register, to m_*.
// Throughput: one word per cycle unless stalled; bucket add/compare is one stage.
// Back pressure on m_tready stalls both stages; the input register drains
// into the result register on the cycle the result slot frees up.
// Reset (rst, synchronous): level 0, mode none, threshold 100, cost 10.
module event_rate_throttle
  import ert_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] is_measurement, [7:1] zero
  input  logic [0:0]           s_tuser,   // [0] operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata    // [0] forward_event, [1] raise_alarm,
                                          // [2] clear_alarm, [4:3] throttle_mode,
                                          // [7:5] zero
);

  cfg_t    cfg;
  result_t result;

  logic    in_valid;
  logic    in_op;
  logic    in_meas;
  logic    out_valid;
  result_t out_word;
  logic    out_free;
  logic    fire;

  ert_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ert_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .step           (fire),
    .operation      (in_op),
    .is_measurement (in_meas),
    .result         (result)
  );

  // Handshake
  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser[0];
      in_meas <= s_tdata[0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_word};

endmodule

// ----- src/ert_checker.sv -----
// Port-level checks for the event rate throttle, bound to the top level.
module ert_checker
  import ert_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Mode code three never appears
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:3] != 2'd3))
    else $error("illegal throttle mode on output");

  // A word either forwards, raises or clears, never two of these
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[2:0]) <= 1))
    else $error("more than one action flag in a result word");

  // Raising the alarm always moves to throttling
  a_raise_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (m_tdata[4:3] == MODE_THROTTLING))
    else $error("alarm raised without entering throttling");

  // Forwarding leaves the mode at none or throttled
  a_fwd_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |->
      (m_tdata[4:3] == MODE_NONE || m_tdata[4:3] == MODE_THROTTLED))
    else $error("forwarded word with throttling mode");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");

endmodule

bind event_rate_throttle ert_checker u_ert_checker (.*);
